// ===== design/cbf_pkg.sv =====
// Package for the circular byte FIFO: operation and status codes and field widths.
// Used by the top level; has no dependencies of its own.
package cbf_pkg;

    localparam int OPCODE_W   = 3;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int CFG_SIZE_W = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE       = 3'd0,
        OP_READ        = 3'd1,
        OP_DISCARD     = 3'd2,
        OP_CLOSE_READ  = 3'd3,
        OP_CLOSE_WRITE = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_CLOSED  = 2'd2
    } status_t;

endpackage

// ===== design/circular_byte_fifo_unit.sv =====
// Circular byte FIFO top level: pointers, close flags, ring size and result register.
// Depends on cbf_pkg and cbf_ring_mem.
// Results are registered; one item is accepted every cycle while the result is free
// or taken, set by the single registered pass and the store's registered read of the
// head byte. The input is held off in any cycle that offers a configuration write.
// Synchronous active-low reset clears the pointers, the close flags and the output
// valid, and sets the ring size to DEPTH; the byte store is not cleared.
module circular_byte_fifo_unit
    import cbf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_SIZE_W-1:0] cfg_buffer_size,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OPCODE_W-1:0]   s_opcode,
    input  logic [BYTE_W-1:0]     s_write_byte,
    input  logic [COUNT_W-1:0]    s_discard_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_read_byte,
    output logic [COUNT_W-1:0]    m_bytes_done,
    output logic [STATUS_W-1:0]   m_status,
    output logic [COUNT_W-1:0]    m_fill_length,
    output logic                  m_read_side_closed,
    output logic                  m_write_side_closed
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH + 1);
    localparam int LW = (SW > COUNT_W) ? SW : COUNT_W;

    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [SW-1:0] size_reg, size_next;
    logic          rd_closed_reg, rd_closed_next;
    logic          wr_closed_reg, wr_closed_next;

    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   rbyte_reg, rbyte_next;
    logic [COUNT_W-1:0]  done_reg, done_next;
    status_t             status_reg, status_next;
    logic [COUNT_W-1:0]  fill_reg, fill_next;

    logic          s_fire;
    logic          cfg_fire;
    logic          mem_we;
    logic [7:0]    head_byte;
    logic [SW-1:0] rp_ext, wp_ext, len, len_after;
    logic [LW-1:0] dc_ext, len_lw, drop_lw;
    logic [SW-1:0] drop;
    logic [SW:0]   rp_sum, wp_sum;
    logic [SW:0]   size_wide;
    logic [SW-1:0] cfg_size;

    assign s_ready   = (!m_valid_reg || m_ready) && !cfg_valid;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign rp_ext = SW'(rp_reg);
    assign wp_ext = SW'(wp_reg);
    assign len    = (wp_reg >= rp_reg) ? (wp_ext - rp_ext) : (size_reg - rp_ext + wp_ext);

    assign dc_ext  = LW'(s_discard_count);
    assign len_lw  = LW'(len);
    assign drop_lw = (dc_ext < len_lw) ? dc_ext : len_lw;
    assign drop    = SW'(drop_lw);

    assign size_wide = (SW+1)'(size_reg);

    always_comb begin
        if (cfg_buffer_size < CFG_SIZE_W'(2)) begin
            cfg_size = SW'(2);
        end else if (32'(cfg_buffer_size) > 32'(DEPTH)) begin
            cfg_size = SW'(DEPTH);
        end else begin
            cfg_size = SW'(cfg_buffer_size);
        end
    end

    always_comb begin
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        size_next      = size_reg;
        rd_closed_next = rd_closed_reg;
        wr_closed_next = wr_closed_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        rbyte_next     = rbyte_reg;
        done_next      = done_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;
        mem_we         = 1'b0;
        len_after      = len;
        rp_sum         = (SW+1)'(rp_ext) + (SW+1)'(drop);
        wp_sum         = (SW+1)'(wp_ext) + (SW+1)'(1);

        if (cfg_fire) begin
            if (len == '0) begin
                size_next = cfg_size;
                rp_next   = '0;
                wp_next   = '0;
            end
        end else if (s_fire) begin
            m_valid_next = 1'b1;
            rbyte_next   = '0;
            done_next    = '0;
            status_next  = ST_OK;
            case (s_opcode)
                OP_WRITE: begin
                    if (rd_closed_reg || ((len + SW'(1)) >= size_reg)) begin
                        status_next = ST_REFUSED;
                    end else begin
                        mem_we    = 1'b1;
                        wp_next   = (wp_sum >= size_wide) ? '0 : PW'(wp_sum);
                        done_next = COUNT_W'(1);
                        len_after = len + SW'(1);
                    end
                end
                OP_READ: begin
                    if (len == '0) begin
                        status_next = ST_REFUSED;
                    end else begin
                        rbyte_next = head_byte;
                        rp_sum     = (SW+1)'(rp_ext) + (SW+1)'(1);
                        rp_next    = (rp_sum >= size_wide) ? '0 : PW'(rp_sum);
                        done_next  = COUNT_W'(1);
                        len_after  = len - SW'(1);
                    end
                end
                OP_DISCARD: begin
                    rp_next   = (rp_sum >= size_wide) ? PW'(rp_sum - size_wide) : PW'(rp_sum);
                    done_next = COUNT_W'(drop_lw);
                    len_after = len - drop;
                end
                OP_CLOSE_READ: begin
                    if (rd_closed_reg) begin
                        status_next = ST_CLOSED;
                    end else begin
                        rd_closed_next = 1'b1;
                    end
                end
                OP_CLOSE_WRITE: begin
                    if (wr_closed_reg) begin
                        status_next = ST_CLOSED;
                    end else begin
                        wr_closed_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            fill_next = COUNT_W'(len_after);
        end
    end

    cbf_ring_mem #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (wp_reg),
        .wr_data (s_write_byte),
        .rd_addr (rp_next),
        .rd_data (head_byte)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            size_reg      <= SW'(DEPTH);
            rd_closed_reg <= 1'b0;
            wr_closed_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            size_reg      <= size_next;
            rd_closed_reg <= rd_closed_next;
            wr_closed_reg <= wr_closed_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rbyte_reg  <= rbyte_next;
        done_reg   <= done_next;
        status_reg <= status_next;
        fill_reg   <= fill_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_read_byte         = rbyte_reg;
    assign m_bytes_done        = done_reg;
    assign m_status            = status_reg;
    assign m_fill_length       = fill_reg;
    assign m_read_side_closed  = rd_closed_reg;
    assign m_write_side_closed = wr_closed_reg;

endmodule

// ===== design/cbf_ring_mem.sv =====
// Byte store of the circular FIFO: one write port and one registered read port.
// The read register takes the byte being written when both addresses match.
// No package dependency.
module cbf_ring_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== bench/circular_byte_fifo_unit_test.sv =====
// Self-checking bench for circular_byte_fifo_unit: directed and random items on the
// valid/ready channels, checked against a scoreboard that tracks the byte ring.
// Depends on cbf_pkg and the design sources; needs no files or arguments at run time.
module circular_byte_fifo_unit_test import cbf_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 100;
    localparam int OPCODE_TOP  = (1 << OPCODE_W) - 1;

    typedef struct {
        logic [BYTE_W-1:0]   read_byte;
        logic [COUNT_W-1:0]  bytes_done;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  fill_length;
        logic                read_side_closed;
        logic                write_side_closed;
    } fifo_reply_t;

    class byte_ring_scoreboard;
        logic [BYTE_W-1:0] ring [RING_DEPTH];
        int unsigned       rd_ptr;
        int unsigned       wr_ptr;
        int unsigned       ring_size;
        bit                rd_closed;
        bit                wr_closed;
        fifo_reply_t       expected_replies[$];
        int                errors;

        function new();
            rd_ptr    = 0;
            wr_ptr    = 0;
            ring_size = RING_DEPTH;
            rd_closed = 1'b0;
            wr_closed = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function int unsigned held();
            if (wr_ptr >= rd_ptr)
                return wr_ptr - rd_ptr;
            return ring_size - rd_ptr + wr_ptr;
        endfunction

        function int unsigned step_ptr(int unsigned p, int unsigned n);
            int unsigned q;
            q = p + n;
            if (q >= ring_size)
                q -= ring_size;
            return q;
        endfunction

        function void note_size(logic [CFG_SIZE_W-1:0] value);
            int unsigned v;
            v = 32'(value);
            if (held() != 0)
                return;
            if (v < 2)
                v = 2;
            if (v > RING_DEPTH)
                v = RING_DEPTH;
            ring_size = v;
            rd_ptr    = 0;
            wr_ptr    = 0;
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [BYTE_W-1:0] wb,
                                   logic [COUNT_W-1:0] dc);
            fifo_reply_t r;
            int unsigned len;
            int unsigned n;
            len          = held();
            r.read_byte  = '0;
            r.bytes_done = '0;
            r.status     = ST_OK;
            case (op)
                OP_WRITE: begin
                    if (rd_closed || len + 1 >= ring_size) begin
                        r.status = ST_REFUSED;
                    end else begin
                        ring[wr_ptr] = wb;
                        wr_ptr       = step_ptr(wr_ptr, 1);
                        r.bytes_done = COUNT_W'(1);
                    end
                end
                OP_READ: begin
                    if (len == 0) begin
                        r.status = ST_REFUSED;
                    end else begin
                        r.read_byte  = ring[rd_ptr];
                        rd_ptr       = step_ptr(rd_ptr, 1);
                        r.bytes_done = COUNT_W'(1);
                    end
                end
                OP_DISCARD: begin
                    n            = (32'(dc) < len) ? 32'(dc) : len;
                    r.bytes_done = COUNT_W'(n);
                    rd_ptr       = step_ptr(rd_ptr, n);
                end
                OP_CLOSE_READ: begin
                    if (rd_closed)
                        r.status = ST_CLOSED;
                    rd_closed = 1'b1;
                end
                OP_CLOSE_WRITE: begin
                    if (wr_closed)
                        r.status = ST_CLOSED;
                    wr_closed = 1'b1;
                end
                default: begin
                end
            endcase
            r.fill_length       = COUNT_W'(held());
            r.read_side_closed  = rd_closed;
            r.write_side_closed = wr_closed;
            expected_replies.push_back(r);
        endfunction

        function void compare(string field, logic [COUNT_W-1:0] want,
                              logic [COUNT_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_reply(fifo_reply_t got);
            fifo_reply_t want;
            if (expected_replies.size() == 0) begin
                $error("reply with no item outstanding, fill_length %0d", got.fill_length);
                errors++;
                return;
            end
            want = expected_replies.pop_front();
            compare("read_byte", COUNT_W'(want.read_byte), COUNT_W'(got.read_byte));
            compare("bytes_done", want.bytes_done, got.bytes_done);
            compare("status", COUNT_W'(want.status), COUNT_W'(got.status));
            compare("fill_length", want.fill_length, got.fill_length);
            compare("read_side_closed", COUNT_W'(want.read_side_closed),
                    COUNT_W'(got.read_side_closed));
            compare("write_side_closed", COUNT_W'(want.write_side_closed),
                    COUNT_W'(got.write_side_closed));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_SIZE_W-1:0] cfg_buffer_size;
    logic                  s_valid;
    logic                  s_ready;
    logic [OPCODE_W-1:0]   s_opcode;
    logic [BYTE_W-1:0]     s_write_byte;
    logic [COUNT_W-1:0]    s_discard_count;
    logic                  m_valid;
    logic                  m_ready;
    logic [BYTE_W-1:0]     m_read_byte;
    logic [COUNT_W-1:0]    m_bytes_done;
    logic [STATUS_W-1:0]   m_status;
    logic [COUNT_W-1:0]    m_fill_length;
    logic                  m_read_side_closed;
    logic                  m_write_side_closed;

    byte_ring_scoreboard sb;
    int                  send_calm = 0;
    int                  cycle_count = 0;

    circular_byte_fifo_unit #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_buffer_size    (cfg_buffer_size),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_write_byte       (s_write_byte),
        .s_discard_count    (s_discard_count),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_byte        (m_read_byte),
        .m_bytes_done       (m_bytes_done),
        .m_status           (m_status),
        .m_fill_length      (m_fill_length),
        .m_read_side_closed (m_read_side_closed),
        .m_write_side_closed(m_write_side_closed)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3) begin
            send_calm = $urandom_range(20, 80);
            return 0;
        end
        if ($urandom_range(0, 99) < 60)
            return 0;
        return pick_gap();
    endfunction

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [BYTE_W-1:0] wb,
                             input logic [COUNT_W-1:0] dc, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_write_byte    <= wb;
        s_discard_count <= dc;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(op, wb, dc);
    endtask

    task automatic hold_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic write_size(input logic [CFG_SIZE_W-1:0] value);
        @(negedge aclk);
        cfg_valid       <= 1'b1;
        cfg_buffer_size <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        sb.note_size(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_item(input int write_pct, input bit last_phase);
        int                  r;
        logic [OPCODE_W-1:0] op;
        logic [COUNT_W-1:0]  dc;
        r = $urandom_range(0, 99);
        if (r < write_pct)
            op = OP_WRITE;
        else if (r < 90)
            op = OP_READ;
        else if (r < 95)
            op = OP_DISCARD;
        else if (r < 97)
            op = OP_CLOSE_WRITE;
        else if (r < 99)
            op = OPCODE_W'($urandom_range(OP_CLOSE_WRITE + 1, OPCODE_TOP));
        else
            op = last_phase ? OP_CLOSE_READ : OP_READ;
        if ($urandom_range(0, 99) < 70)
            dc = COUNT_W'($urandom_range(0, 8));
        else
            dc = COUNT_W'($urandom_range(0, RING_DEPTH - 1));
        send_item(op, BYTE_W'($urandom_range(0, 255)), dc, sender_gap());
    endtask

    initial begin
        int stall;
        int calm;
        stall   = 0;
        calm    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 99) < 2)
                    calm = $urandom_range(20, 80);
                else if ($urandom_range(0, 99) < 25)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        fifo_reply_t got;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            got.read_byte         = m_read_byte;
            got.bytes_done        = m_bytes_done;
            got.status            = m_status;
            got.fill_length       = m_fill_length;
            got.read_side_closed  = m_read_side_closed;
            got.write_side_closed = m_write_side_closed;
            sb.check_reply(got);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int size_value;
        int write_pct;
        int r;
        aresetn         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_buffer_size = '0;
        s_valid         = 1'b0;
        s_opcode        = OP_WRITE;
        s_write_byte    = '0;
        s_discard_count = '0;
        sb = new();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty ring, spare opcodes, then the close-write path, which must not block writes.
        send_item(OP_READ, 8'h00, '0, 0);
        send_item(OP_DISCARD, 8'h00, COUNT_W'(RING_DEPTH - 1), 0);
        for (int k = OP_CLOSE_WRITE + 1; k <= OPCODE_TOP; k++)
            send_item(OPCODE_W'(k), 8'hFF, COUNT_W'(RING_DEPTH - 1), 0);
        send_item(OP_WRITE, 8'h00, '0, 0);
        send_item(OP_WRITE, 8'hFF, '0, 0);
        send_item(OP_WRITE, 8'h5A, '0, 1);
        send_item(OP_DISCARD, 8'h00, '0, 0);
        send_item(OP_READ, 8'h00, '0, 0);
        send_item(OP_CLOSE_WRITE, 8'h00, '0, 0);
        send_item(OP_CLOSE_WRITE, 8'h00, '0, 0);
        send_item(OP_WRITE, 8'hC3, '0, 0);
        send_item(OP_DISCARD, 8'h00, COUNT_W'(1), 0);
        send_item(OP_READ, 8'h00, '0, 0);

        // A size change while a byte is still held has no effect.
        hold_sender();
        wait_idle();
        write_size(CFG_SIZE_W'(4));
        send_item(OP_READ, 8'h00, '0, 0);
        send_item(OP_READ, 8'h00, '0, 0);

        // Smallest ring holds one byte, so the second write is refused.
        hold_sender();
        wait_idle();
        write_size(CFG_SIZE_W'(0));
        send_item(OP_WRITE, 8'h81, '0, 0);
        send_item(OP_WRITE, 8'h7E, '0, 0);
        send_item(OP_READ, 8'h00, '0, 0);
        send_item(OP_WRITE, 8'h7E, '0, 0);
        send_item(OP_READ, 8'h00, '0, 0);
        hold_sender();
        wait_idle();
        write_size(CFG_SIZE_W'(1025));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase % 5 != 4)
                send_item(OP_DISCARD, BYTE_W'($urandom_range(0, 255)),
                          COUNT_W'(RING_DEPTH - 1), sender_gap());
            hold_sender();
            wait_idle();
            case (phase)
                0: size_value = 2;
                1: size_value = 3;
                2: size_value = 2047;
                3: size_value = 1;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        size_value = $urandom_range(2, 16);
                    else if (r < 90)
                        size_value = $urandom_range(17, 200);
                    else
                        size_value = $urandom_range(201, RING_DEPTH);
                end
            endcase
            write_size(CFG_SIZE_W'(size_value));
            write_pct = $urandom_range(30, 65);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == PHASES / 2 && n == PHASE_ITEMS / 2) begin
                    hold_sender();
                    wait_idle();
                end
                if (phase == PHASES - 1 && (n == 40 || n == 41))
                    send_item(OP_CLOSE_READ, BYTE_W'($urandom_range(0, 255)), '0,
                              sender_gap());
                else
                    random_item(write_pct, phase == PHASES - 1);
            end
        end

        hold_sender();
        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
